// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Every property samples on the rising
// clock edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever pre holds, post must hold too.
`define SYR_ASSERT_IMPLY(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication: whenever pre holds, post must hold in the following cycle.
`define SYR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hdl/syr_pkg.sv
package syr_pkg;

   localparam int unsigned CORDIC_W = 34;

   typedef struct packed {
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic signed [31:0] yaw_deg;
      logic signed [31:0] scale_factor;
      logic               suppress_scale;
   } syr_req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } syr_rsp_type;

   // One slot of the rotation chain: CORDIC vector, residual angle and the
   // scaled displacement that rides along with it.
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic signed [32:0]         dx;
      logic signed [32:0]         dy;
      logic signed [31:0]         dz;
   } syr_lane_type;

   // Angles in Q16.16 degrees.
   localparam logic [24:0] TURN          = 25'd23592960;
   localparam logic [24:0] HALF          = 25'd11796480;
   localparam logic [24:0] QUARTER       = 25'd5898240;
   localparam logic [24:0] THREE_QUARTER = 25'd17694720;
   // 2^31 modulo one turn, removed again after the biased reduction.
   localparam logic [24:0] WRAP_OFFSET   = 25'd524288;
   localparam logic [24:0] TURN_LESS_OFFSET = TURN - WRAP_OFFSET;

   // One turn is 45 * 2^19; ceil(2^20 / 45) gives an exact quotient for 13 bits.
   localparam logic [14:0] RECIP_45   = 15'd23302;
   localparam logic [12:0] TURN_DIGIT = 13'd45;

   // round(pi / 180 * 2^32)
   localparam logic signed [27:0] DEG_TO_RAD = 28'sd74961321;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   // Largest residual angle after folding to a quarter turn, Q4.30 radians.
   localparam logic signed [CORDIC_W-1:0] Z_LIMIT     = 34'sd1686629723;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/syr_front.sv
module syr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  req_fire,
   input  syr_pkg::syr_req_type  req_data,
   output logic                  lane_valid_ff,
   output syr_pkg::syr_lane_type lane_ff
);
   import syr_pkg::*;

   // Stage 1: scale products and the quotient digit of the yaw reduction.
   logic               s1_valid_ff;
   logic signed [63:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [63:0] s1_px_in, s1_py_in, s1_pz_in;
   logic [12:0]        s1_turn_ff, s1_turn_in;
   logic [18:0]        s1_frac_ff, s1_frac_in;
   logic [7:0]         s1_q_ff, s1_q_in;
   logic [31:0]        yaw_bias;
   logic [27:0]        q_prod;

   // Stage 2: rounded and saturated scale, yaw modulo one turn.
   logic               s2_valid_ff;
   logic signed [31:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic signed [31:0] s2_dx_in, s2_dy_in, s2_dz_in;
   logic [24:0]        s2_r_ff, s2_r_in;
   logic signed [63:0] t_x, t_y, t_z;
   logic [12:0]        q_mul, digit;
   logic [24:0]        m_val;

   // Stage 3: fold into a half turn centered on zero.
   logic               s3_valid_ff;
   logic signed [31:0] s3_dx_ff, s3_dy_ff, s3_dz_ff;
   logic signed [23:0] s3_angle_ff, s3_angle_in;
   logic               s3_flip_ff, s3_flip_in;
   logic [25:0]        a_wide;

   // Stage 4: degrees to radians; a folded angle negates x and y up front.
   logic               s4_valid_ff;
   logic signed [32:0] s4_dx_ff, s4_dy_ff, s4_dx_in, s4_dy_in;
   logic signed [31:0] s4_dz_ff;
   logic signed [51:0] s4_rad_ff, s4_rad_in;

   // Stage 5: rounded radians seed the rotation chain.
   syr_lane_type       lane_in;
   logic signed [51:0] t_rad;

   always_comb begin
      if (req_data.suppress_scale) begin
         s1_px_in = {{16{req_data.delta_x[31]}}, req_data.delta_x, 16'h0000};
         s1_py_in = {{16{req_data.delta_y[31]}}, req_data.delta_y, 16'h0000};
         s1_pz_in = {{16{req_data.delta_z[31]}}, req_data.delta_z, 16'h0000};
      end else begin
         s1_px_in = 64'($signed(req_data.delta_x)) * 64'($signed(req_data.scale_factor));
         s1_py_in = 64'($signed(req_data.delta_y)) * 64'($signed(req_data.scale_factor));
         s1_pz_in = 64'($signed(req_data.delta_z)) * 64'($signed(req_data.scale_factor));
      end
      // Biasing by 2^31 makes the yaw unsigned; the bias is taken out in stage 2.
      yaw_bias   = {~req_data.yaw_deg[31], req_data.yaw_deg[30:0]};
      s1_turn_in = yaw_bias[31:19];
      s1_frac_in = yaw_bias[18:0];
      q_prod     = 28'(s1_turn_in) * 28'(RECIP_45);
      s1_q_in    = q_prod[27:20];
   end

   always_comb begin
      t_x      = s1_px_ff + 64'sd32768;
      t_y      = s1_py_ff + 64'sd32768;
      t_z      = s1_pz_ff + 64'sd32768;
      s2_dx_in = sat32(t_x[63:16]);
      s2_dy_in = sat32(t_y[63:16]);
      s2_dz_in = sat32(t_z[63:16]);
      q_mul    = 13'(s1_q_ff) * TURN_DIGIT;
      digit    = s1_turn_ff - q_mul;
      m_val    = {digit[5:0], s1_frac_ff};
      if (m_val < WRAP_OFFSET) begin
         s2_r_in = m_val + TURN_LESS_OFFSET;
      end else begin
         s2_r_in = m_val - WRAP_OFFSET;
      end
   end

   always_comb begin
      if (s2_r_ff <= QUARTER) begin
         a_wide     = {1'b0, s2_r_ff};
         s3_flip_in = 1'b0;
      end else if (s2_r_ff < THREE_QUARTER) begin
         a_wide     = {1'b0, s2_r_ff} - {1'b0, HALF};
         s3_flip_in = 1'b1;
      end else begin
         a_wide     = {1'b0, s2_r_ff} - {1'b0, TURN};
         s3_flip_in = 1'b0;
      end
      s3_angle_in = a_wide[23:0];
   end

   always_comb begin
      if (s3_flip_ff) begin
         s4_dx_in = -33'(s3_dx_ff);
         s4_dy_in = -33'(s3_dy_ff);
      end else begin
         s4_dx_in = 33'(s3_dx_ff);
         s4_dy_in = 33'(s3_dy_ff);
      end
      s4_rad_in = 52'(s3_angle_ff) * 52'(DEG_TO_RAD);
   end

   always_comb begin
      t_rad      = s4_rad_ff + 52'sd131072;
      lane_in.x  = CORDIC_GAIN;
      lane_in.y  = '0;
      lane_in.z  = t_rad[51:18];
      lane_in.dx = s4_dx_ff;
      lane_in.dy = s4_dy_ff;
      lane_in.dz = s4_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         lane_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff   <= req_fire;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         lane_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff    <= s1_px_in;
         s1_py_ff    <= s1_py_in;
         s1_pz_ff    <= s1_pz_in;
         s1_turn_ff  <= s1_turn_in;
         s1_frac_ff  <= s1_frac_in;
         s1_q_ff     <= s1_q_in;
         s2_dx_ff    <= s2_dx_in;
         s2_dy_ff    <= s2_dy_in;
         s2_dz_ff    <= s2_dz_in;
         s2_r_ff     <= s2_r_in;
         s3_dx_ff    <= s2_dx_ff;
         s3_dy_ff    <= s2_dy_ff;
         s3_dz_ff    <= s2_dz_ff;
         s3_angle_ff <= s3_angle_in;
         s3_flip_ff  <= s3_flip_in;
         s4_dx_ff    <= s4_dx_in;
         s4_dy_ff    <= s4_dy_in;
         s4_dz_ff    <= s3_dz_ff;
         s4_rad_ff   <= s4_rad_in;
         lane_ff     <= lane_in;
      end
   end

endmodule

// File: hdl/syr_cell.sv
module syr_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  prev_valid,
   input  syr_pkg::syr_lane_type prev_lane,
   output logic                  valid_ff,
   output syr_pkg::syr_lane_type lane_ff
);
   import syr_pkg::*;

   logic signed [CORDIC_W-1:0] x_cur, y_cur, z_cur;
   logic signed [CORDIC_W-1:0] xs, ys, step;
   syr_lane_type               lane_in;

   always_comb begin
      x_cur   = prev_lane.x;
      y_cur   = prev_lane.y;
      z_cur   = prev_lane.z;
      xs      = x_cur >>> STAGE;
      ys      = y_cur >>> STAGE;
      step    = CORDIC_W'(atan_q30(5'(STAGE)));
      lane_in = prev_lane;
      // Turn toward zero residual angle.
      if (!z_cur[CORDIC_W-1]) begin
         lane_in.x = x_cur - ys;
         lane_in.y = y_cur + xs;
         lane_in.z = z_cur - step;
      end else begin
         lane_in.x = x_cur + ys;
         lane_in.y = y_cur - xs;
         lane_in.z = z_cur + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// File: hdl/syr_back.sv
module syr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  lane_valid,
   input  syr_pkg::syr_lane_type lane,
   output logic                  out_valid_ff,
   output syr_pkg::syr_rsp_type  out_data_ff
);
   import syr_pkg::*;

   logic signed [CORDIC_W-1:0] cos_v, sin_v;
   logic signed [32:0]         dx_v, dy_v;

   logic               b1_valid_ff;
   logic signed [66:0] b1_pcx_ff, b1_psy_ff, b1_psx_ff, b1_pcy_ff;
   logic signed [66:0] b1_pcx_in, b1_psy_in, b1_psx_in, b1_pcy_in;
   logic signed [31:0] b1_dz_ff;

   logic               b2_valid_ff;
   logic signed [67:0] b2_sx_ff, b2_sy_ff, b2_sx_in, b2_sy_in;
   logic signed [31:0] b2_dz_ff;

   syr_rsp_type        out_data_in;

   always_comb begin
      cos_v     = lane.x;
      sin_v     = lane.y;
      dx_v      = lane.dx;
      dy_v      = lane.dy;
      b1_pcx_in = 67'(cos_v) * 67'(dx_v);
      b1_psy_in = 67'(sin_v) * 67'(dy_v);
      b1_psx_in = 67'(sin_v) * 67'(dx_v);
      b1_pcy_in = 67'(cos_v) * 67'(dy_v);
   end

   always_comb begin
      b2_sx_in = 68'(b1_pcx_ff) - 68'(b1_psy_ff) + 68'sd536870912;
      b2_sy_in = 68'(b1_psx_ff) + 68'(b1_pcy_ff) + 68'sd536870912;
   end

   always_comb begin
      out_data_in.world_x = sat32(48'($signed(b2_sx_ff[67:30])));
      out_data_in.world_y = sat32(48'($signed(b2_sy_ff[67:30])));
      out_data_in.world_z = b2_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff  <= lane_valid;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_pcx_ff   <= b1_pcx_in;
         b1_psy_ff   <= b1_psy_in;
         b1_psx_ff   <= b1_psx_in;
         b1_pcy_ff   <= b1_pcy_in;
         b1_dz_ff    <= lane.dz;
         b2_sx_ff    <= b2_sx_in;
         b2_sy_ff    <= b2_sy_in;
         b2_dz_ff    <= b1_dz_ff;
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: hdl/scaled_yaw_rotation_xy.sv
// Five front stages, one cell per rotation stage and three back stages lie
// between an accepted item and its result.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while a finished result waits in the output register.
// Reset (synchronous, active high) clears every stage's valid bit; data
// registers are not reset.
`include "assert_macros.svh"

module scaled_yaw_rotation_xy #(
   parameter int unsigned ROTATION_STAGES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  syr_pkg::syr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output syr_pkg::syr_rsp_type rsp_data
);
   import syr_pkg::*;

   logic         adv;
   logic         chain_valid [0:ROTATION_STAGES];
   syr_lane_type chain_lane  [0:ROTATION_STAGES];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   syr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .req_fire      (req_valid && adv),
      .req_data      (req_data),
      .lane_valid_ff (chain_valid[0]),
      .lane_ff       (chain_lane[0])
   );

   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
      syr_cell #(
         .STAGE (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .prev_valid (chain_valid[i]),
         .prev_lane  (chain_lane[i]),
         .valid_ff   (chain_valid[i+1]),
         .lane_ff    (chain_lane[i+1])
      );
   end

   syr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .lane_valid   (chain_valid[ROTATION_STAGES]),
      .lane         (chain_lane[ROTATION_STAGES]),
      .out_valid_ff (rsp_valid),
      .out_data_ff  (rsp_data)
   );

   `SYR_ASSERT_IMPLY(a_stall_blocks_input, rsp_valid && !rsp_ready, !req_ready, "item taken while output stalled")
   `SYR_ASSERT_NEXT(a_stall_keeps_result, !req_ready, rsp_valid, "input blocked without a held result")
   `SYR_ASSERT_IMPLY(a_cordic_seed, chain_valid[0], chain_lane[0].x == CORDIC_GAIN && chain_lane[0].y == '0, "rotation seed is not the gain vector")
   `SYR_ASSERT_IMPLY(a_angle_folded, chain_valid[0], chain_lane[0].z <= Z_LIMIT && chain_lane[0].z >= -Z_LIMIT, "residual angle beyond a quarter turn")

endmodule
